// ----- hw/rtl/planar_to_chunky_palette_expand_macros.svh -----
// Assertion helpers shared by the front, queue and back RTL files.
`ifndef PLANAR_TO_CHUNKY_PALETTE_EXPAND_MACROS_SVH
`define PLANAR_TO_CHUNKY_PALETTE_EXPAND_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define P2C_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("p2c assertion failed");

// Next-cycle implication, checked outside reset.
`define P2C_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("p2c assertion failed");

`endif

// ----- hw/rtl/p2c_pkg.sv -----
package p2c_pkg;

	// Fixed field and register widths.
	localparam int BYTE_W = 8;
	localparam int RGB_W = 24;
	localparam int IDX_W = 4;
	localparam int ROW_W = 15;
	localparam int ROWS_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 1;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_ROW = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd1;

	// Largest number of rows in one frame.
	localparam logic [ROWS_W-1:0] ROWS_MAX = 16'd32768;

	// Plane codes, in arrival order within a row.
	localparam logic [1:0] PLANE_BRIGHT = 2'd0;
	localparam logic [1:0] PLANE_RED = 2'd1;
	localparam logic [1:0] PLANE_GREEN = 2'd2;
	localparam logic [1:0] PLANE_BLUE = 2'd3;

	// Job queue between front and back; the depth is a power of two so the
	// pointers wrap on their own.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_LVL_W = 3;

	// One blue byte with the three stored plane bytes of the same column.
	typedef struct packed {
		logic [BYTE_W-1:0] bright;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic row_last;
		logic frame_last;
	} p2c_job_t;

	// Fixed 16-color palette, red in the top byte.
	function automatic logic [RGB_W-1:0] palette_rgb(input logic [IDX_W-1:0] idx);
		logic [RGB_W-1:0] rgb;
		case (idx)
			4'd0: rgb = 24'h000000;
			4'd1: rgb = 24'h00007F;
			4'd2: rgb = 24'h007F00;
			4'd3: rgb = 24'h007F7F;
			4'd4: rgb = 24'h7F0000;
			4'd5: rgb = 24'h7F007F;
			4'd6: rgb = 24'h7F3F00;
			4'd7: rgb = 24'h7F7F7F;
			4'd8: rgb = 24'h3F3F3F;
			4'd9: rgb = 24'h0000FF;
			4'd10: rgb = 24'h00FF00;
			4'd11: rgb = 24'h00FFFF;
			4'd12: rgb = 24'hFF0000;
			4'd13: rgb = 24'hFF00FF;
			4'd14: rgb = 24'hFFFF00;
			4'd15: rgb = 24'hFFFFFF;
			default: rgb = 24'h000000;
		endcase
		return rgb;
	endfunction

endpackage

// ----- hw/rtl/planar_to_chunky_palette_expand.sv -----
// Planar to chunky converter with a fixed 16-color palette. Each row arrives
// as bytes_per_row bright bytes, then red, green and blue bytes; the first
// three planes are kept in line stores, and every blue byte yields eight
// pixels, leftmost first, each as a 4-bit index and its 24-bit palette color.
// A plane byte is taken while the four-entry job queue, counting the job in
// flight, has room; the pixel serializer puts out one pixel per cycle while
// out_stall is low. A blue byte's pixels pass the stage-1 register, the job
// queue, the job register and the output register. The user must write
// configuration only while the block is idle; the block does not enforce it.
module planar_to_chunky_palette_expand #(
	parameter int MAX_ROW_BYTES = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [p2c_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [p2c_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [p2c_pkg::BYTE_W-1:0]      plane_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [p2c_pkg::RGB_W-1:0]       pixel_rgb,
	output logic [p2c_pkg::IDX_W-1:0]       color_index,
	output logic                            last_of_group,
	output logic                            row_end,
	output logic                            frame_end
);

	import p2c_pkg::*;

	logic                   push;
	p2c_job_t               push_job;
	logic                   pop;
	logic                   not_empty;
	p2c_job_t               head;
	logic [QUEUE_LVL_W-1:0] queue_level;

	// Front: takes plane bytes, fills line stores, forms pixel jobs.
	p2c_front #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.plane_byte (plane_byte),
		.queue_level(queue_level),
		.push       (push),
		.job        (push_job)
	);

	// Queue of jobs between the two halves.
	p2c_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.not_empty(not_empty),
		.head     (head),
		.level    (queue_level)
	);

	// Back: turns each job into eight palette pixels.
	p2c_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.not_empty    (not_empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_rgb    (pixel_rgb),
		.color_index  (color_index),
		.last_of_group(last_of_group),
		.row_end      (row_end),
		.frame_end    (frame_end)
	);

endmodule

// ----- hw/rtl/p2c_ram.sv -----
module p2c_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/p2c_front.sv -----
`include "planar_to_chunky_palette_expand_macros.svh"

module p2c_front #(
	parameter int MAX_ROW_BYTES = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [p2c_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [p2c_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [p2c_pkg::BYTE_W-1:0]          plane_byte,
	input  logic [p2c_pkg::QUEUE_LVL_W-1:0]     queue_level,
	output logic                                push,
	output p2c_pkg::p2c_job_t                   job
);

	import p2c_pkg::*;

	localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam int LEN_W = ($clog2(MAX_ROW_BYTES + 1) > BYTE_W) ?
		$clog2(MAX_ROW_BYTES + 1) : BYTE_W;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_ROW_BYTES);

	logic [BYTE_W-1:0] bytes_per_row_q;
	logic [ROWS_W-1:0] row_count_q;
	logic [1:0]        plane_q;
	logic [ADDR_W-1:0] pos_q;
	logic [ROW_W-1:0]  row_q;

	logic              push_s1;
	logic [BYTE_W-1:0] blue_s1;
	logic              row_last_s1;
	logic              frame_last_s1;

	logic [LEN_W-1:0]       bpr_ext;
	logic [LEN_W-1:0]       len_eff;
	logic [LEN_W-1:0]       pos_inc;
	logic                   at_end;
	logic [ROWS_W-1:0]      rows_eff;
	logic [ROWS_W-1:0]      row_inc;
	logic                   frame_last;
	logic [QUEUE_LVL_W-1:0] occupancy;
	logic                   accept;
	logic                   is_blue;
	logic [BYTE_W-1:0]      bright_rd;
	logic [BYTE_W-1:0]      red_rd;
	logic [BYTE_W-1:0]      green_rd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_per_row_q <= 8'd1;
			row_count_q <= 16'd1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_BYTES_PER_ROW: bytes_per_row_q <= cfg_data[BYTE_W-1:0];
				CFG_ROW_COUNT: row_count_q <= cfg_data[ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective row length and the end-of-plane test.
	always_comb begin
		bpr_ext = LEN_W'(bytes_per_row_q);
		if (bpr_ext == '0) begin
			len_eff = LEN_W'(1);
		end else if (bpr_ext > LEN_MAX) begin
			len_eff = LEN_MAX;
		end else begin
			len_eff = bpr_ext;
		end
		pos_inc = LEN_W'(pos_q) + LEN_W'(1);
		at_end = (pos_inc >= len_eff);
	end

	// Effective frame height and the end-of-frame test.
	always_comb begin
		if (row_count_q == '0) begin
			rows_eff = 16'd1;
		end else if (row_count_q > ROWS_MAX) begin
			rows_eff = ROWS_MAX;
		end else begin
			rows_eff = row_count_q;
		end
		row_inc = {1'b0, row_q} + 16'd1;
		frame_last = (row_inc >= rows_eff);
	end

	// Hold input off while the queue plus the job in flight could fill it.
	assign occupancy = queue_level + QUEUE_LVL_W'(push_s1);
	assign in_stall = (occupancy >= QUEUE_LVL_W'(QUEUE_DEPTH));
	assign accept = in_valid && !in_stall;
	assign is_blue = (plane_q == PLANE_BLUE);

	// Line stores for the first three planes.
	p2c_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_ROW_BYTES),
		.ADDR_W(ADDR_W)
	) u_bright_line (
		.clk    (clk),
		.wr_en  (accept && (plane_q == PLANE_BRIGHT)),
		.wr_addr(pos_q),
		.wr_data(plane_byte),
		.rd_en  (accept && is_blue),
		.rd_addr(pos_q),
		.rd_data(bright_rd)
	);

	p2c_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_ROW_BYTES),
		.ADDR_W(ADDR_W)
	) u_red_line (
		.clk    (clk),
		.wr_en  (accept && (plane_q == PLANE_RED)),
		.wr_addr(pos_q),
		.wr_data(plane_byte),
		.rd_en  (accept && is_blue),
		.rd_addr(pos_q),
		.rd_data(red_rd)
	);

	p2c_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_ROW_BYTES),
		.ADDR_W(ADDR_W)
	) u_green_line (
		.clk    (clk),
		.wr_en  (accept && (plane_q == PLANE_GREEN)),
		.wr_addr(pos_q),
		.wr_data(plane_byte),
		.rd_en  (accept && is_blue),
		.rd_addr(pos_q),
		.rd_data(green_rd)
	);

	// Plane, column and row tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= PLANE_BRIGHT;
			pos_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (at_end) begin
				pos_q <= '0;
				if (is_blue) begin
					plane_q <= PLANE_BRIGHT;
					row_q <= frame_last ? '0 : row_inc[ROW_W-1:0];
				end else begin
					plane_q <= plane_q + 2'd1;
				end
			end else begin
				pos_q <= pos_q + ADDR_W'(1);
			end
		end
	end

	// Stage 1 waits for the line store reads of a blue byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_s1 <= 1'b0;
		end else begin
			push_s1 <= accept && is_blue;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_blue) begin
			blue_s1 <= plane_byte;
			row_last_s1 <= at_end;
			frame_last_s1 <= at_end && frame_last;
		end
	end

	assign push = push_s1;
	assign job = '{
		bright: bright_rd,
		red: red_rd,
		green: green_rd,
		blue: blue_s1,
		row_last: row_last_s1,
		frame_last: frame_last_s1
	};

	`P2C_ASSERT_IMPLIES(a_push_has_room, clk, arst_n, push_s1,
		queue_level < QUEUE_LVL_W'(QUEUE_DEPTH))
	`P2C_ASSERT_IMPLIES(a_frame_end_is_row_end, clk, arst_n, push_s1 && frame_last_s1,
		row_last_s1)

endmodule

// ----- hw/rtl/p2c_queue.sv -----
`include "planar_to_chunky_palette_expand_macros.svh"

module p2c_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  p2c_pkg::p2c_job_t               push_job,
	input  logic                            pop,
	output logic                            not_empty,
	output p2c_pkg::p2c_job_t               head,
	output logic [p2c_pkg::QUEUE_LVL_W-1:0] level
);

	import p2c_pkg::*;

	p2c_job_t               slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_LVL_W-1:0] level_q;

	// Job storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + QUEUE_LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - QUEUE_LVL_W'(1);
			end
		end
	end

	assign not_empty = (level_q != '0);
	assign head = slot_q[rd_ptr_q];
	assign level = level_q;

	`P2C_ASSERT_IMPLIES(a_no_overflow, clk, arst_n, push && !pop,
		level_q < QUEUE_LVL_W'(QUEUE_DEPTH))
	`P2C_ASSERT_IMPLIES(a_no_underflow, clk, arst_n, pop, level_q != '0)

endmodule

// ----- hw/rtl/p2c_back.sv -----
`include "planar_to_chunky_palette_expand_macros.svh"

module p2c_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       not_empty,
	input  p2c_pkg::p2c_job_t          head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [p2c_pkg::RGB_W-1:0]  pixel_rgb,
	output logic [p2c_pkg::IDX_W-1:0]  color_index,
	output logic                       last_of_group,
	output logic                       row_end,
	output logic                       frame_end
);

	import p2c_pkg::*;

	p2c_job_t         job_q;
	logic             job_valid_q;
	logic [2:0]       cnt_q;
	logic             out_valid_q;
	logic [RGB_W-1:0] rgb_q;
	logic [IDX_W-1:0] idx_q;
	logic             last_q;
	logic             row_end_q;
	logic             frame_end_q;

	logic             load_pixel;
	logic             job_done;
	logic [2:0]       bit_sel;
	logic [IDX_W-1:0] idx;

	// A pixel moves into the output register whenever it is free or drains.
	assign load_pixel = job_valid_q && (!out_valid_q || !out_stall);
	assign job_done = load_pixel && (cnt_q == 3'd7);
	assign pop = not_empty && (!job_valid_q || job_done);

	// Pixels go out most significant bit first.
	assign bit_sel = ~cnt_q;
	assign idx = {job_q.bright[bit_sel], job_q.red[bit_sel],
		job_q.green[bit_sel], job_q.blue[bit_sel]};

	// Current job and pixel counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (pop) begin
				job_valid_q <= 1'b1;
			end else if (job_done) begin
				job_valid_q <= 1'b0;
			end
			if (load_pixel) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_pixel) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_pixel) begin
			rgb_q <= palette_rgb(idx);
			idx_q <= idx;
			last_q <= (cnt_q == 3'd7);
			row_end_q <= (cnt_q == 3'd7) && job_q.row_last;
			frame_end_q <= (cnt_q == 3'd7) && job_q.frame_last;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_rgb = rgb_q;
	assign color_index = idx_q;
	assign last_of_group = last_q;
	assign row_end = row_end_q;
	assign frame_end = frame_end_q;

	`P2C_ASSERT_IMPLIES(a_row_end_on_last, clk, arst_n, out_valid_q && row_end_q, last_q)
	`P2C_ASSERT_NEXT(a_pop_starts_job, clk, arst_n, pop, job_valid_q && (cnt_q == 3'd0))

endmodule
